FILE: sv/ps2_device_reset_identify_defines.svh
// Assertion macros for the PS/2 device reset and identify sequencer.
`ifndef PS2_DEVICE_RESET_IDENTIFY_DEFINES_SVH
`define PS2_DEVICE_RESET_IDENTIFY_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PS2DRI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ps2dri assertion failed");
// next-cycle implication
`define PS2DRI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ps2dri assertion failed");
`else
`define PS2DRI_ASSERT_NOW(label, ante, cons)
`define PS2DRI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/ps2dri_pkg.sv
// Types and constants shared by the PS/2 reset and identify sequencer.
`timescale 1ns / 1ps
package ps2dri_pkg;

	localparam int unsigned TimeoutW = 10;
	localparam int unsigned RetryW   = 4;
	localparam int unsigned CfgIdxW  = 2;

	localparam logic [TimeoutW-1:0] TIMEOUT_RST = 10'd100;
	localparam logic [RetryW-1:0]   RETRY_RST   = 4'd5;

	localparam logic [CfgIdxW-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RETRY   = 2'd1;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_BYTE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [7:0] DEV_RESET    = 8'hFF;
	localparam logic [7:0] RESP_RESEND  = 8'hFE;
	localparam logic [7:0] RESP_BAT_OK  = 8'hAA;
	localparam logic [7:0] ID_MOUSE_STD = 8'h00;
	localparam logic [7:0] ID_MOUSE_3   = 8'h03;
	localparam logic [7:0] ID_MOUSE_4   = 8'h04;
	localparam logic [7:0] ID_KBD_LEAD  = 8'hAB;

	localparam logic EVT_TX   = 1'b0;
	localparam logic EVT_DONE = 1'b1;

	typedef enum logic [1:0] {
		OUT_FAILED   = 2'd0,
		OUT_KEYBOARD = 2'd1,
		OUT_MOUSE    = 2'd2,
		OUT_UNKNOWN  = 2'd3
	} outcome_t;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_WAIT_ACK = 5'b00010,
		PH_WAIT_BAT = 5'b00100,
		PH_WAIT_ID1 = 5'b01000,
		PH_WAIT_ID2 = 5'b10000
	} phase_t;

endpackage

FILE: sv/ps2dri_if.sv
// Channel interfaces: command words in, event words out, register writes.
`timescale 1ns / 1ps
interface ps2dri_req_if import ps2dri_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] rx_byte;
	modport source (output valid, cmd, rx_byte, input ready);
	modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface ps2dri_evt_if import ps2dri_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [7:0] tx_byte;
	logic [1:0] outcome;
	modport source (output valid, event_kind, tx_byte, outcome, input ready);
	modport sink (input valid, event_kind, tx_byte, outcome, output ready);
endinterface

interface ps2dri_cfg_if import ps2dri_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [15:0]        data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/ps2_device_reset_identify.sv
// PS/2 device reset and identify sequencer, top level.
// An accepted command word that yields an event word presents it from the event register in the next cycle.
// Throughput: one command word per cycle; a held event word stalls input only
// while the event register is full and not being taken.
// Reset (arst_n low): phase idle, counters zero, timeout 100 ms, retry limit 5.
`timescale 1ns / 1ps
`include "ps2_device_reset_identify_defines.svh"
module ps2_device_reset_identify import ps2dri_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	ps2dri_cfg_if.sink   cfg,
	ps2dri_req_if.sink   req,
	ps2dri_evt_if.source evt
);

	logic [TimeoutW-1:0] timeout_q;
	logic [RetryW-1:0]   retry_q;
	phase_t              phase_q, phase_d;
	logic [RetryW-1:0]   tries_q, tries_d;
	logic [TimeoutW-1:0] elapsed_q, elapsed_d;
	logic [TimeoutW:0]   elapsed_inc;

	logic     evt_valid_q;
	logic     evt_kind_q;
	outcome_t evt_outcome_q;

	logic     acc;
	logic     emit_tx;
	logic     done;
	outcome_t done_out;

	assign cfg.ready = 1'b1;
	assign req.ready = !evt_valid_q || evt.ready;
	assign acc       = req.valid && req.ready;

	assign elapsed_inc = {1'b0, elapsed_q} + {{TimeoutW{1'b0}}, 1'b1};

	always_comb begin
		phase_d   = phase_q;
		tries_d   = tries_q;
		elapsed_d = elapsed_q;
		emit_tx   = 1'b0;
		done      = 1'b0;
		done_out  = OUT_FAILED;
		case (req.cmd)
			CMD_START: begin
				if (retry_q == '0) begin
					tries_d = '0;
					done    = 1'b1;
				end else begin
					tries_d   = retry_q - {{(RetryW-1){1'b0}}, 1'b1};
					phase_d   = PH_WAIT_ACK;
					elapsed_d = '0;
					emit_tx   = 1'b1;
				end
			end
			CMD_BYTE: begin
				unique case (phase_q)
					PH_WAIT_ACK: begin
						if (req.rx_byte == RESP_RESEND) begin
							if (tries_q == '0) begin
								done = 1'b1;
							end else begin
								tries_d   = tries_q - {{(RetryW-1){1'b0}}, 1'b1};
								elapsed_d = '0;
								emit_tx   = 1'b1;
							end
						end else begin
							phase_d   = PH_WAIT_BAT;
							elapsed_d = '0;
						end
					end
					PH_WAIT_BAT: begin
						if (req.rx_byte == RESP_BAT_OK) begin
							phase_d   = PH_WAIT_ID1;
							elapsed_d = '0;
						end else begin
							done = 1'b1;
						end
					end
					PH_WAIT_ID1: begin
						if (req.rx_byte == ID_MOUSE_STD || req.rx_byte == ID_MOUSE_3 ||
						    req.rx_byte == ID_MOUSE_4) begin
							done     = 1'b1;
							done_out = OUT_MOUSE;
						end else if (req.rx_byte == ID_KBD_LEAD) begin
							phase_d   = PH_WAIT_ID2;
							elapsed_d = '0;
						end else begin
							done     = 1'b1;
							done_out = OUT_UNKNOWN;
						end
					end
					PH_WAIT_ID2: begin
						done     = 1'b1;
						done_out = OUT_KEYBOARD;
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (elapsed_inc <= {1'b0, timeout_q}) begin
						elapsed_d = elapsed_inc[TimeoutW-1:0];
					end else begin
						done = 1'b1;
						unique case (phase_q)
							PH_WAIT_ID1: done_out = OUT_KEYBOARD;
							PH_WAIT_ID2: done_out = OUT_UNKNOWN;
							default:     done_out = OUT_FAILED;
						endcase
					end
				end
			end
			default: ;
		endcase
		if (done) begin
			phase_d   = PH_IDLE;
			elapsed_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			retry_q   <= RETRY_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TIMEOUT: timeout_q <= cfg.data[TimeoutW-1:0];
				REG_RETRY:   retry_q   <= cfg.data[RetryW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tries_q   <= '0;
			elapsed_q <= '0;
		end else if (acc) begin
			phase_q   <= phase_d;
			tries_q   <= tries_d;
			elapsed_q <= elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (acc) begin
			evt_valid_q <= emit_tx || done;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	// event payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc && (emit_tx || done)) begin
			evt_kind_q    <= done ? EVT_DONE : EVT_TX;
			evt_outcome_q <= done ? done_out : OUT_FAILED;
		end
	end

	assign evt.valid      = evt_valid_q;
	assign evt.event_kind = evt_kind_q;
	assign evt.tx_byte    = (evt_kind_q == EVT_TX) ? DEV_RESET : 8'h00;
	assign evt.outcome    = evt_outcome_q;

	`PS2DRI_ASSERT_NOW(a_idle_no_count, phase_q == PH_IDLE, elapsed_q == '0)
	`PS2DRI_ASSERT_NEXT(a_done_to_idle, acc && done, phase_q == PH_IDLE)
	`PS2DRI_ASSERT_NOW(a_stall_blocks_in, evt_valid_q && !evt.ready, !req.ready)
	`PS2DRI_ASSERT_NOW(a_tx_clean, evt.valid && evt.event_kind == EVT_TX,
		evt.outcome == OUT_FAILED && evt.tx_byte == DEV_RESET)

endmodule

FILE: tb/sv/ps2_device_reset_identify_tb.sv
`timescale 1ns / 1ps
// Testbench for the PS/2 reset and identify sequencer: directed and random command words.
module ps2_device_reset_identify_tb import ps2dri_pkg::*; ();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RX_HOLD_LEN = 60;

	typedef struct packed {
		logic       event_kind;
		logic [7:0] tx_byte;
		outcome_t   outcome;
	} evt_word_t;

	logic clk;
	logic arst_n;

	ps2dri_cfg_if cfg_ch ();
	ps2dri_req_if req_ch ();
	ps2dri_evt_if evt_ch ();

	ps2_device_reset_identify dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.evt   (evt_ch)
	);

	phase_t              seq_phase;
	logic [RetryW-1:0]   seq_tries;
	logic [TimeoutW-1:0] seq_elapsed;
	logic [TimeoutW-1:0] seq_timeout;
	logic [RetryW-1:0]   seq_retry_limit;

	evt_word_t pending_events[$];
	int        mismatches = 0;
	int        tx_idle_pct;
	int        rx_idle_pct;
	int        rx_hold_reqs;
	int        rx_hold_done = 0;
	int        rx_hold_cycles = 0;

	always #10 clk = ~clk;

	function automatic evt_word_t finish_seq(input outcome_t result);
		seq_phase = PH_IDLE;
		seq_elapsed = '0;
		return '{EVT_DONE, 8'h00, result};
	endfunction

	function automatic bit predict_event(input logic [1:0] cmd, input logic [7:0] rx,
		output evt_word_t w);
		logic [TimeoutW:0] next_ms;
		w = '{EVT_TX, DEV_RESET, OUT_FAILED};
		case (cmd)
			CMD_START: begin
				if (seq_retry_limit == 0) begin
					seq_tries = '0;
					w = finish_seq(OUT_FAILED);
				end else begin
					seq_tries = seq_retry_limit - 1'b1;
					seq_phase = PH_WAIT_ACK;
					seq_elapsed = '0;
				end
				return 1'b1;
			end
			CMD_BYTE: begin
				case (seq_phase)
					PH_WAIT_ACK: begin
						if (rx != RESP_RESEND) begin
							seq_phase = PH_WAIT_BAT;
							seq_elapsed = '0;
							return 1'b0;
						end
						if (seq_tries == 0) begin
							w = finish_seq(OUT_FAILED);
						end else begin
							seq_tries = seq_tries - 1'b1;
							seq_elapsed = '0;
						end
						return 1'b1;
					end
					PH_WAIT_BAT: begin
						if (rx == RESP_BAT_OK) begin
							seq_phase = PH_WAIT_ID1;
							seq_elapsed = '0;
							return 1'b0;
						end
						w = finish_seq(OUT_FAILED);
						return 1'b1;
					end
					PH_WAIT_ID1: begin
						if (rx == ID_KBD_LEAD) begin
							seq_phase = PH_WAIT_ID2;
							seq_elapsed = '0;
							return 1'b0;
						end
						if (rx == ID_MOUSE_STD || rx == ID_MOUSE_3 || rx == ID_MOUSE_4)
							w = finish_seq(OUT_MOUSE);
						else
							w = finish_seq(OUT_UNKNOWN);
						return 1'b1;
					end
					PH_WAIT_ID2: begin
						w = finish_seq(OUT_KEYBOARD);
						return 1'b1;
					end
					default: return 1'b0;
				endcase
			end
			CMD_TICK: begin
				if (seq_phase == PH_IDLE)
					return 1'b0;
				next_ms = {1'b0, seq_elapsed} + 1'b1;
				if (next_ms <= {1'b0, seq_timeout}) begin
					seq_elapsed = next_ms[TimeoutW-1:0];
					return 1'b0;
				end
				case (seq_phase)
					PH_WAIT_ID1: w = finish_seq(OUT_KEYBOARD);
					PH_WAIT_ID2: w = finish_seq(OUT_UNKNOWN);
					default: w = finish_seq(OUT_FAILED);
				endcase
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void report_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [7:0] rx);
		evt_word_t w;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.rx_byte <= rx;
		do @(posedge clk); while (!req_ch.ready);
		if (predict_event(cmd, rx, w))
			pending_events.push_back(w);
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_word(CMD_TICK, 8'($urandom_range(255)));
	endtask

	task automatic drain_events();
		int guard;
		guard = 0;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_events.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		// event register latency, plus margin for words that produce nothing
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_TIMEOUT)
			seq_timeout = value[TimeoutW-1:0];
		else if (idx == REG_RETRY)
			seq_retry_limit = value[RetryW-1:0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_hold_done != rx_hold_reqs) begin
			rx_hold_done <= rx_hold_reqs;
			rx_hold_cycles <= RX_HOLD_LEN;
			evt_ch.ready <= 1'b0;
		end else if (rx_hold_cycles > 0) begin
			evt_ch.ready <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			evt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : event_check
		evt_word_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (pending_events.size() == 0) begin
				report_error($sformatf("unexpected event: kind %0d tx %02h outcome %0d",
					evt_ch.event_kind, evt_ch.tx_byte, evt_ch.outcome));
			end else begin
				want = pending_events.pop_front();
				if (evt_ch.event_kind !== want.event_kind || evt_ch.tx_byte !== want.tx_byte ||
					evt_ch.outcome !== want.outcome)
					report_error($sformatf(
						"event mismatch: expected kind %0d tx %02h outcome %0d, got %0d %02h %0d",
						want.event_kind, want.tx_byte, want.outcome,
						evt_ch.event_kind, evt_ch.tx_byte, evt_ch.outcome));
			end
		end
	end

	// reset values: stray words ignored, then resends run out
	task automatic test_default_resend_limit();
		send_word(CMD_BYTE, RESP_BAT_OK);
		send_word(CMD_TICK, 8'h5A);
		send_word(CMD_UNUSED, 8'hFF);
		send_word(CMD_START, 8'h00);
		repeat (5) send_word(CMD_BYTE, RESP_RESEND);
		drain_events();
	endtask

	task automatic test_zero_limits();
		write_reg(REG_RETRY, 16'd0);
		send_word(CMD_START, 8'hC3);
		drain_events();
		write_reg(REG_RETRY, 16'd15);
		write_reg(REG_TIMEOUT, 16'd0);
		send_word(CMD_START, 8'h3C);
		send_word(CMD_TICK, 8'h00);
		drain_events();
	endtask

	task automatic test_restart_while_busy();
		write_reg(REG_TIMEOUT, 16'd2);
		send_word(CMD_START, 8'h00);
		send_word(CMD_BYTE, 8'h00);
		send_word(CMD_START, 8'hFF);
		send_word(CMD_BYTE, 8'h12);
		send_word(CMD_BYTE, RESP_BAT_OK);
		send_ticks(2);
		send_word(CMD_BYTE, ID_KBD_LEAD);
		send_word(CMD_BYTE, 8'hFF);
		drain_events();
	endtask

	task automatic test_timeout_lowered();
		write_reg(REG_TIMEOUT, 16'd1000);
		send_word(CMD_START, 8'h81);
		send_word(CMD_BYTE, 8'hFA);
		send_ticks(3);
		drain_events();
		write_reg(REG_TIMEOUT, 16'd1);
		send_word(CMD_TICK, 8'h7E);
		drain_events();
	endtask

	task automatic test_backpressure();
		rx_hold_reqs++;
		repeat (16) send_word(CMD_START, 8'($urandom_range(255)));
		drain_events();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct,
		input logic [15:0] tmo, input logic [15:0] rty, input int n_words);
		int         sent;
		int         pick;
		int         burst;
		logic [7:0] rx;
		drain_events();
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_RETRY, rty);
		sent = 0;
		while (sent < n_words) begin
			pick = $urandom_range(99);
			rx = 8'($urandom_range(255));
			burst = $urandom_range(1, 4);
			if (pick < 6) begin
				send_word(2'($urandom_range(3)), rx);
				sent++;
			end else begin
				case (seq_phase)
					PH_IDLE: begin
						send_word(CMD_START, rx);
						sent++;
					end
					PH_WAIT_ACK: begin
						if (pick < 40) begin
							send_word(CMD_BYTE, RESP_RESEND);
							sent++;
						end else if (pick < 55) begin
							send_ticks(burst);
							sent += burst;
						end else begin
							send_word(CMD_BYTE, rx);
							sent++;
						end
					end
					PH_WAIT_BAT: begin
						if (pick < 75) begin
							send_word(CMD_BYTE, RESP_BAT_OK);
							sent++;
						end else if (pick < 85) begin
							send_ticks(burst);
							sent += burst;
						end else begin
							send_word(CMD_BYTE, rx);
							sent++;
						end
					end
					PH_WAIT_ID1: begin
						if (pick < 25) begin
							case ($urandom_range(2))
								0: send_word(CMD_BYTE, ID_MOUSE_STD);
								1: send_word(CMD_BYTE, ID_MOUSE_3);
								default: send_word(CMD_BYTE, ID_MOUSE_4);
							endcase
							sent++;
						end else if (pick < 55) begin
							send_word(CMD_BYTE, ID_KBD_LEAD);
							sent++;
						end else if (pick < 75) begin
							send_ticks(burst);
							sent += burst;
						end else begin
							send_word(CMD_BYTE, rx);
							sent++;
						end
					end
					default: begin
						if (pick < 55) begin
							send_word(CMD_BYTE, rx);
							sent++;
						end else begin
							send_ticks(burst);
							sent += burst;
						end
					end
				endcase
			end
		end
		drain_events();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		tx_idle_pct = 38;
		rx_idle_pct = 67;
		rx_hold_reqs = 0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_TICK;
		req_ch.rx_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TIMEOUT;
		cfg_ch.data = 16'h0000;
		seq_timeout = TIMEOUT_RST;
		seq_retry_limit = RETRY_RST;
		seq_phase = PH_IDLE;
		seq_tries = '0;
		seq_elapsed = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_resend_limit();
		test_zero_limits();
		test_restart_while_busy();
		test_timeout_lowered();
		test_backpressure();
		test_random_traffic(38, 67, 16'd3, 16'd2, 300);
		test_random_traffic(67, 38, 16'd1, 16'd15, 300);
		test_random_traffic(0, 0, 16'd1000, 16'd1, 120);
		test_random_traffic(0, 0, 16'd5, 16'd4, 180);

		drain_events();
		repeat (10) @(posedge clk);
		if (pending_events.size() != 0)
			$display("%0t: %0d expected event words never arrived", $time,
				pending_events.size());
		if (mismatches == 0 && pending_events.size() == 0)
			$display("PASS ps2_device_reset_identify");
		else
			$display("FAIL ps2_device_reset_identify");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAIL ps2_device_reset_identify");
		$finish;
	end

endmodule
